[src/gcpvt_pkg.sv]
// shared types and constants for the graphics command port
`timescale 1ns / 1ps
`default_nettype none
package gcpvt_pkg;

  localparam logic [1:0] KIND_GP0_WRITE = 2'd0;
  localparam logic [1:0] KIND_GP1_WRITE = 2'd1;
  localparam logic [1:0] KIND_GP0_READ  = 2'd2;
  localparam logic [1:0] KIND_STAT_READ = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] data;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP_ADDR,
    ST_UP_WR,
    ST_DL_ADDR,
    ST_DL_RD,
    ST_DL_DATA,
    ST_DL_END
  } state_t;

  localparam logic [31:0] STATUS_RESET = 32'h1480_2000;

  // gp0 command codes
  localparam logic [7:0] GP0_FILL     = 8'h02;
  localparam logic [7:0] GP0_UPLOAD   = 8'hA0;
  localparam logic [7:0] GP0_DOWNLOAD = 8'hC0;
  localparam logic [7:0] GP0_DRAWMODE = 8'hE1;
  localparam logic [7:0] GP0_ATTR_LO  = 8'hE2;
  localparam logic [7:0] GP0_ATTR_HI  = 8'hE6;

  // gp1 command codes
  localparam logic [7:0] GP1_RESET    = 8'h00;
  localparam logic [7:0] GP1_FIFO_CLR = 8'h01;
  localparam logic [7:0] GP1_IRQ_ACK  = 8'h02;
  localparam logic [7:0] GP1_DISPLAY  = 8'h03;
  localparam logic [7:0] GP1_DMA      = 8'h04;
  localparam logic [7:0] GP1_MODE     = 8'h08;
  localparam logic [7:0] GP1_READSEL  = 8'h10;

  // read select codes
  localparam logic [3:0] SEL_ATTR_LO  = 4'd2;
  localparam logic [3:0] SEL_ATTR_HI  = 4'd5;
  localparam logic [3:0] SEL_VERSION  = 4'd7;
  localparam logic [3:0] SEL_ZERO     = 4'd8;

  localparam int BIT_DISPLAY_OFF = 23;
  localparam int BIT_IRQ         = 24;
  localparam int BIT_DRQ         = 25;
  localparam int BIT_READ_READY  = 27;
  localparam int BIT_WRITE_EMPTY = 28;

endpackage
`default_nettype wire

[src/gpu_command_port_vram_transfer.sv]
// a status or latch read is answered through the result register once it reaches the head of the queue
// throughput: gp1 and command words 1 per cycle while no transfer or clear is under way; a pixel word
// or a pixel read takes one address step and one access per pixel of the single-port frame memory
// reset: synchronous; afterwards the frame memory is zeroed one entry per cycle, all
// VRAM_COLUMNS * VRAM_ROWS entries (524288 by default), while input items wait in the queue
`timescale 1ns / 1ps
`default_nettype none
module gpu_command_port_vram_transfer #(
  parameter int VRAM_COLUMNS  = 1024,
  parameter int VRAM_ROWS     = 512,
  parameter int COMMAND_DEPTH = 3
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_push,
  output logic        in_full,
  input  wire  [1:0]  in_kind,
  input  wire  [31:0] in_data,
  output logic        out_empty,
  input  wire         out_pop,
  output logic [31:0] out_read_data
);

  gcpvt_pkg::item_t in_item, head;
  logic head_valid, head_pop, out_valid;

  assign in_item.kind = in_kind;
  assign in_item.data = in_data;
  assign out_empty    = !out_valid;

  gcpvt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .full       (in_full),
    .item       (in_item),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  gcpvt_back #(
    .VRAM_COLUMNS  (VRAM_COLUMNS),
    .VRAM_ROWS     (VRAM_ROWS),
    .COMMAND_DEPTH (COMMAND_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_data   (out_read_data),
    .out_pop    (out_pop)
  );

endmodule
`default_nettype wire

[src/gcpvt_front.sv]
// front end: two-entry queue of incoming bus accesses
`timescale 1ns / 1ps
`default_nettype none
module gcpvt_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  output logic                full,
  input  gcpvt_pkg::item_t    item,
  output logic                head_valid,
  output gcpvt_pkg::item_t    head,
  input  wire                 head_pop
);

  gcpvt_pkg::item_t q_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= ~wptr_r;
      if (do_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wptr_r] <= item;
  end

endmodule
`default_nettype wire

[src/gcpvt_back.sv]
// back end: command decode, status, vram transfers and result register
`timescale 1ns / 1ps
`default_nettype none
module gcpvt_back #(
  parameter int VRAM_COLUMNS  = 1024,
  parameter int VRAM_ROWS     = 512,
  parameter int COMMAND_DEPTH = 3
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               head_valid,
  input  gcpvt_pkg::item_t  head,
  output logic              head_pop,
  output logic              out_valid,
  output logic [31:0]       out_data,
  input  wire               out_pop
);

  localparam int MEM_DEPTH = VRAM_COLUMNS * VRAM_ROWS;
  localparam int AW  = $clog2(MEM_DEPTH);
  localparam int HW  = $clog2(COMMAND_DEPTH + 1);
  localparam int CIW = $clog2(COMMAND_DEPTH);
  // wrap steps needed for the largest coordinate sums
  localparam int XN  = 2046 / VRAM_COLUMNS;
  localparam int YN  = 1022 / VRAM_ROWS;
  localparam logic [10:0]   COLS_X = 11'(VRAM_COLUMNS);
  localparam logic [9:0]    ROWS_Y = 10'(VRAM_ROWS);
  localparam logic [AW-1:0] COLS_A = AW'(VRAM_COLUMNS);
  localparam logic [AW-1:0] LAST_A = AW'(MEM_DEPTH - 1);

  function automatic logic [AW-1:0] cell_of(input logic [18:0] org, input logic [18:0] pos);
    logic [10:0] x;
    logic [9:0]  y;
    x = {1'b0, org[18:9]} + {1'b0, pos[18:9]};
    y = {1'b0, org[8:0]} + {1'b0, pos[8:0]};
    for (int i = 0; i < XN; i++) begin
      if (x >= COLS_X) x = x - COLS_X;
    end
    for (int i = 0; i < YN; i++) begin
      if (y >= ROWS_Y) y = y - ROWS_Y;
    end
    return AW'(y) * COLS_A + AW'(x);
  endfunction

  function automatic logic [18:0] next_pos(input logic [18:0] pos, input logic [9:0] w);
    logic [10:0] cx;
    logic [8:0]  cy;
    cx = {1'b0, pos[18:9]} + 11'd1;
    cy = pos[8:0];
    if (cx >= {1'b0, w}) begin
      cx = 11'd0;
      cy = cy + 9'd1;
    end
    return {cx[9:0], cy};
  endfunction

  gcpvt_pkg::state_t state_r, state_nxt;

  logic [31:0] status_r, status_nxt, latch_r, latch_nxt;
  logic [31:0] cmd_r [COMMAND_DEPTH];
  logic        cmd_we;
  logic [HW-1:0] held_r, held_nxt;
  logic [1:0]  exp_r, exp_nxt, dma_r, dma_nxt;
  logic [23:0] attr_r [6];
  logic        attr_we;
  logic [2:0]  attr_idx;
  logic [23:0] attr_val;
  logic        up_act_r, up_act_nxt;
  logic [18:0] up_org_r, up_org_nxt, up_pos_r, up_pos_nxt, up_left_r, up_left_nxt;
  logic [9:0]  up_w_r, up_w_nxt;
  logic        dl_act_r, dl_act_nxt;
  logic [18:0] dl_org_r, dl_org_nxt, dl_pos_r, dl_pos_nxt, dl_left_r, dl_left_nxt;
  logic [18:0] dl_words_r, dl_words_nxt;
  logic [9:0]  dl_w_r, dl_w_nxt;
  logic        half_r, half_nxt;
  logic [AW-1:0] addr_r, addr_nxt, clr_r, clr_nxt;
  logic [31:0] data_r, data_nxt;
  logic [15:0] lo_r, lo_nxt, hi_r, hi_nxt, rdata_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem [MEM_DEPTH];

  // command gather helpers
  logic [7:0]  code;
  logic [23:0] p;
  logic [1:0]  exp_eff;
  logic [HW:0] held_inc;
  logic        done;
  logic [31:0] w0, c1, c2;
  logic [18:0] pixels;
  logic [19:0] pixels_inc;
  logic [18:0] words_dec;

  assign code       = head.data[31:24];
  assign p          = head.data[23:0];
  assign exp_eff    = (held_r != '0) ? exp_r :
                      ((code == gcpvt_pkg::GP0_FILL || code == gcpvt_pkg::GP0_UPLOAD ||
                        code == gcpvt_pkg::GP0_DOWNLOAD) ? 2'd3 : 2'd1);
  assign held_inc   = {1'b0, held_r} + (HW+1)'(1);
  assign done       = (held_inc >= (HW+1)'(exp_eff)) || (held_inc >= (HW+1)'(COMMAND_DEPTH));
  assign w0         = (held_r == HW'(0)) ? head.data : cmd_r[0];
  assign c1         = (held_r == HW'(1)) ? head.data : cmd_r[1];
  assign c2         = (held_r == HW'(2)) ? head.data : cmd_r[2];
  assign pixels     = {9'd0, c2[25:16]} * {10'd0, c2[8:0]};
  assign pixels_inc = {1'b0, pixels} + 20'd1;
  assign words_dec  = (dl_words_r == '0) ? '0 : dl_words_r - 19'd1;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    latch_nxt     = latch_r;
    held_nxt      = held_r;
    exp_nxt       = exp_r;
    dma_nxt       = dma_r;
    cmd_we        = 1'b0;
    attr_we       = 1'b0;
    attr_idx      = 3'd0;
    attr_val      = w0[23:0];
    up_act_nxt    = up_act_r;
    up_org_nxt    = up_org_r;
    up_pos_nxt    = up_pos_r;
    up_left_nxt   = up_left_r;
    up_w_nxt      = up_w_r;
    dl_act_nxt    = dl_act_r;
    dl_org_nxt    = dl_org_r;
    dl_pos_nxt    = dl_pos_r;
    dl_left_nxt   = dl_left_r;
    dl_words_nxt  = dl_words_r;
    dl_w_nxt      = dl_w_r;
    half_nxt      = half_r;
    addr_nxt      = addr_r;
    clr_nxt       = clr_r;
    data_nxt      = data_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    head_pop      = 1'b0;
    out_valid_nxt = out_valid_r && !out_pop;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_addr      = addr_r;
    mem_wdata     = half_r ? data_r[31:16] : data_r[15:0];

    case (state_r)
      gcpvt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = 16'd0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_A) state_nxt = gcpvt_pkg::ST_IDLE;
      end
      gcpvt_pkg::ST_IDLE: begin
        if (head_valid) begin
          case (head.kind)
            gcpvt_pkg::KIND_GP0_WRITE: begin
              head_pop = 1'b1;
              if (up_act_r) begin
                data_nxt  = head.data;
                half_nxt  = 1'b0;
                state_nxt = gcpvt_pkg::ST_UP_ADDR;
              end else begin
                exp_nxt = exp_eff;
                cmd_we  = 1'b1;
                if (done) begin
                  held_nxt = '0;
                  case (w0[31:24])
                    gcpvt_pkg::GP0_UPLOAD: begin
                      up_act_nxt  = 1'b1;
                      up_org_nxt  = {c1[25:16], c1[8:0]};
                      up_w_nxt    = c2[25:16];
                      up_pos_nxt  = '0;
                      up_left_nxt = pixels;
                    end
                    gcpvt_pkg::GP0_DOWNLOAD: begin
                      dl_act_nxt   = 1'b1;
                      dl_org_nxt   = {c1[25:16], c1[8:0]};
                      dl_w_nxt     = c2[25:16];
                      dl_pos_nxt   = '0;
                      dl_left_nxt  = pixels;
                      dl_words_nxt = pixels_inc[19:1];
                      status_nxt[gcpvt_pkg::BIT_READ_READY] = 1'b1;
                    end
                    gcpvt_pkg::GP0_DRAWMODE: begin
                      attr_we             = 1'b1;
                      attr_idx            = 3'd0;
                      status_nxt[10:0]    = w0[10:0];
                      status_nxt[15]      = w0[11];
                    end
                    default: begin
                      if (w0[31:24] >= gcpvt_pkg::GP0_ATTR_LO &&
                          w0[31:24] <= gcpvt_pkg::GP0_ATTR_HI) begin
                        attr_we  = 1'b1;
                        attr_idx = 3'(w0[31:24] - gcpvt_pkg::GP0_DRAWMODE);
                      end
                    end
                  endcase
                end else begin
                  held_nxt = held_inc[HW-1:0];
                end
              end
            end
            gcpvt_pkg::KIND_GP1_WRITE: begin
              head_pop = 1'b1;
              case (code)
                gcpvt_pkg::GP1_RESET: status_nxt = gcpvt_pkg::STATUS_RESET;
                gcpvt_pkg::GP1_FIFO_CLR: begin
                  held_nxt = '0;
                  exp_nxt  = 2'd0;
                end
                gcpvt_pkg::GP1_IRQ_ACK: status_nxt[gcpvt_pkg::BIT_IRQ] = 1'b0;
                gcpvt_pkg::GP1_DISPLAY: status_nxt[gcpvt_pkg::BIT_DISPLAY_OFF] = p[0];
                gcpvt_pkg::GP1_DMA: begin
                  dma_nxt           = p[1:0];
                  status_nxt[30:29] = p[1:0];
                end
                gcpvt_pkg::GP1_MODE: begin
                  status_nxt[18:17] = p[1:0];
                  status_nxt[19]    = p[2];
                  status_nxt[20]    = p[3];
                  status_nxt[21]    = p[4];
                  status_nxt[22]    = p[5];
                  status_nxt[16]    = p[6];
                  status_nxt[14]    = p[7];
                end
                gcpvt_pkg::GP1_READSEL: begin
                  if (p[3:0] >= gcpvt_pkg::SEL_ATTR_LO && p[3:0] <= gcpvt_pkg::SEL_ATTR_HI)
                    latch_nxt = {8'd0, attr_r[3'(p[3:0] - 4'd1)]};
                  else if (p[3:0] == gcpvt_pkg::SEL_VERSION)
                    latch_nxt = 32'd2;
                  else if (p[3:0] == gcpvt_pkg::SEL_ZERO)
                    latch_nxt = 32'd0;
                end
                default: ;
              endcase
            end
            gcpvt_pkg::KIND_GP0_READ: begin
              if (!out_valid_r) begin
                head_pop = 1'b1;
                if (dl_act_r) begin
                  lo_nxt    = 16'd0;
                  hi_nxt    = 16'd0;
                  half_nxt  = 1'b0;
                  state_nxt = gcpvt_pkg::ST_DL_ADDR;
                end else begin
                  out_valid_nxt = 1'b1;
                  out_data_nxt  = latch_r;
                end
              end
            end
            default: begin
              if (!out_valid_r) begin
                head_pop      = 1'b1;
                out_valid_nxt = 1'b1;
                out_data_nxt  = status_r;
              end
            end
          endcase
        end
      end
      gcpvt_pkg::ST_UP_ADDR: begin
        if (up_left_r == '0) begin
          up_act_nxt = 1'b0;
          status_nxt[gcpvt_pkg::BIT_WRITE_EMPTY] = 1'b1;
          state_nxt = gcpvt_pkg::ST_IDLE;
        end else begin
          addr_nxt  = cell_of(up_org_r, up_pos_r);
          state_nxt = gcpvt_pkg::ST_UP_WR;
        end
      end
      gcpvt_pkg::ST_UP_WR: begin
        mem_we      = 1'b1;
        up_left_nxt = up_left_r - 19'd1;
        up_pos_nxt  = next_pos(up_pos_r, up_w_r);
        if (!half_r) begin
          half_nxt  = 1'b1;
          state_nxt = gcpvt_pkg::ST_UP_ADDR;
        end else begin
          if (up_left_r == 19'd1) begin
            up_act_nxt = 1'b0;
            status_nxt[gcpvt_pkg::BIT_WRITE_EMPTY] = 1'b1;
          end
          state_nxt = gcpvt_pkg::ST_IDLE;
        end
      end
      gcpvt_pkg::ST_DL_ADDR: begin
        if (dl_left_r == '0) begin
          state_nxt = gcpvt_pkg::ST_DL_END;
        end else begin
          addr_nxt  = cell_of(dl_org_r, dl_pos_r);
          state_nxt = gcpvt_pkg::ST_DL_RD;
        end
      end
      gcpvt_pkg::ST_DL_RD: begin
        dl_pos_nxt  = next_pos(dl_pos_r, dl_w_r);
        dl_left_nxt = dl_left_r - 19'd1;
        state_nxt   = gcpvt_pkg::ST_DL_DATA;
      end
      gcpvt_pkg::ST_DL_DATA: begin
        if (!half_r) begin
          lo_nxt    = rdata_r;
          half_nxt  = 1'b1;
          state_nxt = gcpvt_pkg::ST_DL_ADDR;
        end else begin
          hi_nxt    = rdata_r;
          state_nxt = gcpvt_pkg::ST_DL_END;
        end
      end
      gcpvt_pkg::ST_DL_END: begin
        dl_words_nxt = words_dec;
        if (words_dec == '0) begin
          dl_act_nxt = 1'b0;
          status_nxt[gcpvt_pkg::BIT_READ_READY] = 1'b0;
        end
        latch_nxt = {hi_r, lo_r};
        status_nxt[gcpvt_pkg::BIT_DRQ] = (dma_r == 2'd1 && held_r != '0) ||
          (dma_r == 2'd2 && dl_act_nxt && words_dec != '0);
        out_valid_nxt = 1'b1;
        out_data_nxt  = {hi_r, lo_r};
        state_nxt     = gcpvt_pkg::ST_IDLE;
      end
      default: state_nxt = gcpvt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcpvt_pkg::ST_CLEAR;
      clr_r       <= '0;
      status_r    <= gcpvt_pkg::STATUS_RESET;
      latch_r     <= '0;
      held_r      <= '0;
      exp_r       <= '0;
      dma_r       <= '0;
      up_act_r    <= 1'b0;
      up_org_r    <= '0;
      up_pos_r    <= '0;
      up_left_r   <= '0;
      up_w_r      <= '0;
      dl_act_r    <= 1'b0;
      dl_org_r    <= '0;
      dl_pos_r    <= '0;
      dl_left_r   <= '0;
      dl_words_r  <= '0;
      dl_w_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) attr_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      status_r    <= status_nxt;
      latch_r     <= latch_nxt;
      held_r      <= held_nxt;
      exp_r       <= exp_nxt;
      dma_r       <= dma_nxt;
      up_act_r    <= up_act_nxt;
      up_org_r    <= up_org_nxt;
      up_pos_r    <= up_pos_nxt;
      up_left_r   <= up_left_nxt;
      up_w_r      <= up_w_nxt;
      dl_act_r    <= dl_act_nxt;
      dl_org_r    <= dl_org_nxt;
      dl_pos_r    <= dl_pos_nxt;
      dl_left_r   <= dl_left_nxt;
      dl_words_r  <= dl_words_nxt;
      dl_w_r      <= dl_w_nxt;
      out_valid_r <= out_valid_nxt;
      if (attr_we) attr_r[attr_idx] <= attr_val;
    end
  end

  always_ff @(posedge clk) begin
    half_r     <= half_nxt;
    addr_r     <= addr_nxt;
    data_r     <= data_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
    if (cmd_we) cmd_r[held_r[CIW-1:0]] <= head.data;
  end

  // single-port frame memory, read-first
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_r <= mem[mem_addr];
  end

endmodule
`default_nettype wire

[src/gcpvt_checker.sv]
// port-level checks for the graphics command port
`timescale 1ns / 1ps
`default_nettype none
module gcpvt_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_push,
  input wire        in_full,
  input wire        out_empty,
  input wire        out_pop,
  input wire [31:0] out_read_data
);

  // reset empties both queues
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // the input queue only fills on a push
  a_full_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("full rose without a push");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_read_data)))
    else $error("result dropped or changed while waiting");

endmodule

bind gpu_command_port_vram_transfer gcpvt_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_push       (in_push),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_read_data (out_read_data)
);
`default_nettype wire
